// File: src/http_message_framer_top_macros.svh
// Assertion macros shared by the framer checker.
`ifndef HTTP_MESSAGE_FRAMER_TOP_MACROS_SVH
`define HTTP_MESSAGE_FRAMER_TOP_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define HMF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked during reset too.
`define HMF_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/hmf_pkg.sv
`default_nettype none

package hmf_pkg;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam int KEY_IDX_BITS = 4;
    localparam logic [KEY_IDX_BITS-1:0] KEY_LEN = 4'd14;

    typedef enum logic [1:0] {
        KIND_HEADER     = 2'd0,
        KIND_HEADER_END = 2'd1,
        KIND_BODY       = 2'd2,
        KIND_SURPLUS    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] lower;
        logic       is_cr;
        logic       is_lf;
        logic       is_colon;
        logic       is_space;
        logic       is_digit;
        logic [3:0] digit;
    } t_class;

    typedef struct packed {
        logic [7:0]  out_byte;
        t_kind       byte_kind;
        logic        header_done;
        logic        message_done;
        logic        error_code;
        logic        length_present;
        logic [31:0] content_length;
    } t_result;

    // Lower-case "content-length", one character per index.
    function automatic logic [7:0] hmf_key_char(input logic [KEY_IDX_BITS-1:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h63; // c
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h6C; // l
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic t_class hmf_classify(input logic [7:0] b);
        t_class c;
        c.data     = b;
        c.lower    = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? b + CASE_OFFSET : b;
        c.is_cr    = (b == CHAR_CR);
        c.is_lf    = (b == CHAR_LF);
        c.is_colon = (b == CHAR_COLON);
        c.is_space = (b == CHAR_SPACE);
        c.is_digit = (b >= CHAR_ZERO && b <= CHAR_NINE);
        c.digit    = b[3:0];
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/hmf_fifo.sv
`default_nettype none

module hmf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PtrBits   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CountBits = $clog2(DEPTH + 1);
    localparam logic [PtrBits-1:0]   LastIdx  = PtrBits'(DEPTH - 1);
    localparam logic [CountBits-1:0] FullCnt  = CountBits'(DEPTH);

    logic [WIDTH-1:0]     r_mem [DEPTH];
    logic [PtrBits-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PtrBits-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CountBits-1:0] r_count, n_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == FullCnt);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LastIdx) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LastIdx) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: src/hmf_front.sv
`default_nettype none

module hmf_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire logic [7:0]      i_in_byte,
    output logic                 o_full,
    input  wire logic            i_take,
    output logic                 o_item_valid,
    output hmf_pkg::t_class      o_item
);

    import hmf_pkg::*;

    t_class                    item_class;
    logic [$bits(t_class)-1:0] q_data;
    logic                      q_empty;

    assign item_class = hmf_classify(i_in_byte);

    hmf_fifo #(
        .WIDTH ($bits(t_class)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (item_class),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    assign o_item_valid = !q_empty;
    assign o_item       = t_class'(q_data);

endmodule

`default_nettype wire

// File: src/hmf_back.sv
`default_nettype none

module hmf_back #(
    parameter int LENGTH_BITS = 32,
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_item_valid,
    input  wire hmf_pkg::t_class i_item,
    output logic                 o_take,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output hmf_pkg::t_result     o_result
);

    import hmf_pkg::*;

    localparam int WideBits = LENGTH_BITS + 4;
    localparam t_class CrClass = hmf_classify(CHAR_CR);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_DONE   = 2'd2,
        PH_ERROR  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        PART_NAME   = 2'd0,
        PART_SPACE  = 2'd1,
        PART_DIGITS = 2'd2,
        PART_IGNORE = 2'd3
    } t_part;

    typedef struct packed {
        logic                    has_bytes;
        t_part                   part;
        logic [KEY_IDX_BITS-1:0] idx;
        logic                    mismatch;
        logic                    found;
        logic [LENGTH_BITS-1:0]  acc;
        logic                    valid;
    } t_line;

    // Advance the line parser by one byte that is not part of the line end.
    function automatic t_line line_byte(input t_line s, input logic first_seen,
                                        input t_class c);
        t_line               r;
        logic [WideBits-1:0] base;
        logic [WideBits-1:0] wide;
        r = s;
        r.has_bytes = 1'b1;
        base = (s.part == PART_SPACE) ? '0 : {4'b0, s.acc};
        wide = (base << 3) + (base << 1) + {{(WideBits-4){1'b0}}, c.digit};
        if (first_seen) begin
            case (s.part)
                PART_NAME: begin
                    if (s.found) begin
                        r.part = PART_IGNORE;
                    end else if (c.is_colon) begin
                        if (!s.mismatch && s.idx == KEY_LEN) begin
                            r.found = 1'b1;
                            r.acc   = '0;
                            r.valid = 1'b0;
                            r.part  = PART_SPACE;
                        end else begin
                            r.part = PART_IGNORE;
                        end
                    end else if (s.idx < KEY_LEN && c.lower == hmf_key_char(s.idx)) begin
                        r.idx = s.idx + 1'b1;
                    end else begin
                        r.mismatch = 1'b1;
                    end
                end
                PART_SPACE, PART_DIGITS: begin
                    if (!(c.is_space && s.part == PART_SPACE)) begin
                        if (c.is_digit && wide[WideBits-1 -: 4] == 4'd0) begin
                            r.acc   = wide[LENGTH_BITS-1:0];
                            r.valid = 1'b1;
                            r.part  = PART_DIGITS;
                        end else begin
                            // Drop the value on a bad character or on overflow.
                            r.acc   = '0;
                            r.valid = 1'b0;
                            r.part  = PART_IGNORE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        return r;
    endfunction

    t_phase                 r_phase, n_phase;
    logic                   r_cr, n_cr;
    logic                   r_first, n_first;
    t_line                  r_line, n_line;
    logic [LENGTH_BITS-1:0] r_count, n_count;

    t_line                   line_a;
    t_kind                   kind;
    logic                    hdone;
    logic                    mdone;
    logic                    out_full;
    logic [LENGTH_BITS+31:0] acc_ext;
    t_result                 result;
    logic [$bits(t_result)-1:0] out_data;

    assign o_take = i_item_valid && !out_full;

    always_comb begin
        n_phase = r_phase;
        n_cr    = r_cr;
        n_first = r_first;
        n_line  = r_line;
        n_count = r_count;
        line_a  = r_line;
        kind    = KIND_HEADER;
        hdone   = 1'b0;
        mdone   = 1'b0;
        case (r_phase)
            PH_HEADER: begin
                if (r_cr && i_item.is_lf) begin
                    n_cr = 1'b0;
                    if (!r_line.has_bytes) begin
                        kind  = KIND_HEADER_END;
                        hdone = 1'b1;
                        if (!r_line.found) begin
                            mdone   = 1'b1;
                            n_phase = PH_DONE;
                        end else if (!r_line.valid) begin
                            n_phase = PH_ERROR;
                        end else if (r_line.acc == '0) begin
                            mdone   = 1'b1;
                            n_phase = PH_DONE;
                        end else begin
                            n_count = '0;
                            n_phase = PH_BODY;
                        end
                    end else begin
                        n_first = 1'b1;
                    end
                    n_line.has_bytes = 1'b0;
                    n_line.part      = PART_NAME;
                    n_line.idx       = '0;
                    n_line.mismatch  = 1'b0;
                end else begin
                    // A held CR not followed by LF belongs to the line.
                    if (r_cr) begin
                        line_a = line_byte(r_line, r_first, CrClass);
                    end
                    if (i_item.is_cr) begin
                        n_cr   = 1'b1;
                        n_line = line_a;
                    end else begin
                        n_cr   = 1'b0;
                        n_line = line_byte(line_a, r_first, i_item);
                    end
                end
            end
            PH_BODY: begin
                kind    = KIND_BODY;
                n_count = r_count + 1'b1;
                if (n_count == r_line.acc) begin
                    mdone   = 1'b1;
                    n_phase = PH_DONE;
                end
            end
            default: begin
                kind = KIND_SURPLUS;
            end
        endcase
    end

    assign acc_ext = {32'b0, n_line.acc};

    always_comb begin
        result.out_byte       = i_item.data;
        result.byte_kind      = kind;
        result.header_done    = hdone;
        result.message_done   = mdone;
        result.error_code     = (n_phase == PH_ERROR);
        result.length_present = n_line.found;
        result.content_length = n_line.valid ? acc_ext[31:0] : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_cr    <= 1'b0;
            r_first <= 1'b0;
            r_line  <= '{has_bytes: 1'b0, part: PART_NAME, idx: '0, mismatch: 1'b0,
                         found: 1'b0, acc: '0, valid: 1'b0};
            r_count <= '0;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_cr    <= n_cr;
            r_first <= n_first;
            r_line  <= n_line;
            r_count <= n_count;
        end
    end

    hmf_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (o_take),
        .i_data  (result),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (out_data)
    );

    assign o_result = t_result'(out_data);

endmodule

`default_nettype wire

// File: src/http_message_framer_top.sv
// Each byte's result is formed combinationally and enters the result queue as the byte is taken.
// Throughput: one byte per cycle, set by the parser step in the back end, while the result queue has room.
// The input queue and the result queue each hold QUEUE_DEPTH items.
// Reset is synchronous and active low; it empties both queues and returns the parser
// to the start of a header. No clearing pass is needed.
`default_nettype none

module http_message_framer_top #(
    parameter int LENGTH_BITS = 32,
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_last_of_chunk,
    input  wire logic        pop,
    output logic             empty,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_byte_kind,
    output logic             o_header_done,
    output logic             o_message_done,
    output logic             o_error_code,
    output logic             o_length_present,
    output logic [31:0]      o_content_length
);

    import hmf_pkg::*;

    t_class  item;
    logic    item_valid;
    logic    take;
    t_result result;

    hmf_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_in_byte    (i_in_byte),
        .o_full       (full),
        .i_take       (take),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    hmf_back #(
        .LENGTH_BITS (LENGTH_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_take       (take),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (result)
    );

    assign o_out_byte       = result.out_byte;
    assign o_byte_kind      = result.byte_kind;
    assign o_header_done    = result.header_done;
    assign o_message_done   = result.message_done;
    assign o_error_code     = result.error_code;
    assign o_length_present = result.length_present;
    assign o_content_length = result.content_length;

endmodule

`default_nettype wire

// File: src/hmf_checker.sv
`default_nettype none

`include "http_message_framer_top_macros.svh"

module hmf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       full,
    input wire logic       empty,
    input wire logic [1:0] o_byte_kind,
    input wire logic       o_header_done,
    input wire logic       o_message_done,
    input wire logic       o_error_code
);

    import hmf_pkg::*;

    `HMF_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, empty, "result queue not empty after reset")

    `HMF_ASSERT_NEXT(a_reset_not_full, i_clk, !i_rst_n, !full, "input queue full after reset")

    `HMF_ASSERT_NOW(a_hdone_kind, i_clk, i_rst_n, !empty && o_header_done, o_byte_kind == KIND_HEADER_END, "header_done off the header-ending LF")

    `HMF_ASSERT_NOW(a_error_surplus, i_clk, i_rst_n, !empty && o_error_code && o_byte_kind != KIND_HEADER_END, o_byte_kind == KIND_SURPLUS, "error item not marked surplus")

    `HMF_ASSERT_NOW(a_mdone_not_surplus, i_clk, i_rst_n, !empty && o_message_done, o_byte_kind != KIND_SURPLUS && !o_error_code, "message_done on surplus or error item")

endmodule

bind http_message_framer_top hmf_checker u_hmf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .o_byte_kind    (o_byte_kind),
    .o_header_done  (o_header_done),
    .o_message_done (o_message_done),
    .o_error_code   (o_error_code)
);

`default_nettype wire

// File: bench/tb_http_message_framer_top.sv
module tb_http_message_framer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hmf_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int REPORT_LIMIT    = 10;
    localparam longint unsigned LENGTH_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam logic [7:0] CHAR_TAB = 8'h09;

    typedef enum logic [1:0] {
        PHASE_HEADER, PHASE_BODY, PHASE_DONE, PHASE_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        PART_NAME, PART_SPACE, PART_DIGITS, PART_IGNORE
    } t_part;

    typedef enum int {
        LEN_VALID, LEN_ZERO, LEN_INVALID, LEN_ABSENT, LEN_EMPTY_START
    } t_length_case;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        push            = 1'b0;
    logic        full;
    logic [7:0]  i_in_byte       = 8'h00;
    logic        i_last_of_chunk = 1'b0;
    logic        pop             = 1'b0;
    logic        empty;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_byte_kind;
    logic        o_header_done;
    logic        o_message_done;
    logic        o_error_code;
    logic        o_length_present;
    logic [31:0] o_content_length;

    http_message_framer_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_in_byte        (i_in_byte),
        .i_last_of_chunk  (i_last_of_chunk),
        .pop              (pop),
        .empty            (empty),
        .o_out_byte       (o_out_byte),
        .o_byte_kind      (o_byte_kind),
        .o_header_done    (o_header_done),
        .o_message_done   (o_message_done),
        .o_error_code     (o_error_code),
        .o_length_present (o_length_present),
        .o_content_length (o_content_length)
    );

    always #5 i_clk = ~i_clk;

    // Framer state as seen by the bench, starting from reset values.
    string                   length_key      = "content-length";
    t_phase                  ph              = PHASE_HEADER;
    logic                    cr_pending      = 1'b0;
    logic                    line_has_bytes  = 1'b0;
    logic                    first_line_seen = 1'b0;
    t_part                   part            = PART_NAME;
    logic [KEY_IDX_BITS-1:0] name_idx        = '0;
    logic                    name_miss       = 1'b0;
    logic                    length_found    = 1'b0;
    longint unsigned         value_acc       = 0;
    logic                    value_valid     = 1'b0;
    longint unsigned         body_count      = 0;

    t_result      framed_q[$];
    int           fault_count   = 0;
    int           cycle_count   = 0;
    int           burst_left    = 0;
    logic         stall_request = 1'b0;
    int           holdoff_left  = 0;
    logic         draining      = 1'b0;
    int           pop_mode      = 0;
    int           mode_left     = 0;
    t_length_case length_case   = LEN_VALID;
    int unsigned  body_len      = 0;

    function automatic void take_line_byte(input logic [7:0] c);
        logic [7:0]      lc;
        longint unsigned d;
        longint unsigned acc;
        line_has_bytes = 1'b1;
        if (!first_line_seen) return;
        lc = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
        case (part)
            PART_NAME: begin
                if (length_found) begin
                    part = PART_IGNORE;
                end else if (c == CHAR_COLON) begin
                    if (!name_miss && name_idx == KEY_LEN) begin
                        length_found = 1'b1;
                        value_acc    = 0;
                        value_valid  = 1'b0;
                        part         = PART_SPACE;
                    end else begin
                        part = PART_IGNORE;
                    end
                end else if (name_idx < KEY_LEN && lc == length_key[name_idx]) begin
                    name_idx++;
                end else begin
                    name_miss = 1'b1;
                end
            end
            PART_SPACE, PART_DIGITS: begin
                if (!(c == CHAR_SPACE && part == PART_SPACE)) begin
                    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                        d   = 64'(c - CHAR_ZERO);
                        acc = (part == PART_SPACE) ? 0 : value_acc;
                        if (acc > (LENGTH_MAX - d) / 10) begin
                            value_valid = 1'b0;
                            value_acc   = 0;
                            part        = PART_IGNORE;
                        end else begin
                            value_acc   = acc * 10 + d;
                            value_valid = 1'b1;
                            part        = PART_DIGITS;
                        end
                    end else begin
                        value_valid = 1'b0;
                        value_acc   = 0;
                        part        = PART_IGNORE;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_result frame_next_byte(input logic [7:0] c);
        t_result r;
        t_kind   kind;
        logic    hdone;
        logic    mdone;
        kind  = KIND_HEADER;
        hdone = 1'b0;
        mdone = 1'b0;
        case (ph)
            PHASE_HEADER: begin
                if (cr_pending && c == CHAR_LF) begin
                    cr_pending = 1'b0;
                    if (!line_has_bytes) begin
                        kind  = KIND_HEADER_END;
                        hdone = 1'b1;
                        if (!length_found) begin
                            mdone = 1'b1;
                            ph    = PHASE_DONE;
                        end else if (!value_valid) begin
                            ph = PHASE_ERROR;
                        end else if (value_acc == 0) begin
                            mdone = 1'b1;
                            ph    = PHASE_DONE;
                        end else begin
                            body_count = 0;
                            ph         = PHASE_BODY;
                        end
                    end else begin
                        first_line_seen = 1'b1;
                    end
                    line_has_bytes = 1'b0;
                    part           = PART_NAME;
                    name_idx       = '0;
                    name_miss      = 1'b0;
                end else begin
                    // a CR held back from the previous byte belongs to the line
                    if (cr_pending) take_line_byte(CHAR_CR);
                    if (c == CHAR_CR) begin
                        cr_pending = 1'b1;
                    end else begin
                        cr_pending = 1'b0;
                        take_line_byte(c);
                    end
                end
            end
            PHASE_BODY: begin
                kind = KIND_BODY;
                body_count++;
                if (body_count >= value_acc) begin
                    mdone = 1'b1;
                    ph    = PHASE_DONE;
                end
            end
            default: kind = KIND_SURPLUS;
        endcase
        r.out_byte       = c;
        r.byte_kind      = kind;
        r.header_done    = hdone;
        r.message_done   = mdone;
        r.error_code     = (ph == PHASE_ERROR);
        r.length_present = length_found;
        r.content_length = value_valid ? value_acc[31:0] : 32'd0;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                push = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        push            = 1'b1;
        i_in_byte       = b;
        i_last_of_chunk = 1'($urandom_range(0, 1));
        do @(posedge i_clk); while (full);
        framed_q.push_back(frame_next_byte(b));
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_line_end();
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    // Key in random letter case, then the colon.
    task automatic send_length_key();
        logic [7:0] c;
        for (int i = 0; i < length_key.len(); i++) begin
            c = length_key[i];
            if (c != "-" && $urandom_range(0, 1) == 1) c = c - CASE_OFFSET;
            send_byte(c);
        end
        send_byte(CHAR_COLON);
    endtask

    task automatic wait_drained();
        push = 1'b0;
        while (framed_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_start_line();
        if (length_case == LEN_EMPTY_START) begin
            send_line_end();
        end else begin
            // bare CR inside the line and another one right before the line end
            send_text("GET /index.html");
            send_byte(CHAR_CR);
            send_text("HTTP/1.1");
            send_byte(CHAR_CR);
            send_line_end();
        end
    endtask

    task automatic test_other_header_lines();
        string      near_miss[6] = '{"Content-Lengt", "Content-Lengths", "XContent-Length",
                                     "Content-Length ", "Content_Length", "Content-Length-"};
        int         n;
        int         k;
        logic [7:0] c;
        n = $urandom_range(2, 5);
        repeat (n) begin
            case ($urandom_range(0, 2))
                0: begin
                    send_text(near_miss[$urandom_range(0, 5)]);
                    send_text(": 12");
                end
                1: begin
                    // no colon at all
                    send_text("Content-Length 12");
                end
                default: begin
                    k = $urandom_range(0, 10);
                    repeat (k) begin
                        c = 8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
                        if ($urandom_range(0, 1) == 1) c = c + CASE_OFFSET;
                        send_byte(c);
                    end
                    send_byte(CHAR_COLON);
                    k = $urandom_range(0, 20);
                    repeat (k) begin
                        c = 8'($urandom_range(0, 255));
                        if (c == CHAR_CR) c = CHAR_LF;
                        send_byte(c);
                    end
                    if ($urandom_range(0, 2) == 0) send_byte(CHAR_CR);
                end
            endcase
            send_line_end();
        end
    endtask

    task automatic test_length_line();
        int k;
        if (length_case == LEN_VALID || length_case == LEN_ZERO ||
            length_case == LEN_INVALID) begin
            send_length_key();
            k = $urandom_range(0, 3);
            repeat (k) send_byte(CHAR_SPACE);
            case (length_case)
                LEN_VALID: begin
                    body_len = $urandom_range(100, 300);
                    k = $urandom_range(0, 2);
                    repeat (k) send_byte(CHAR_ZERO);
                    send_text($sformatf("%0d", body_len));
                end
                LEN_ZERO: begin
                    body_len = 0;
                    if ($urandom_range(0, 1) == 1) send_text("000");
                    else send_text("0");
                end
                default: begin
                    case ($urandom_range(0, 8))
                        0: ;
                        1: send_text("   ");
                        2: begin
                            send_byte(CHAR_TAB);
                            send_text("12");
                        end
                        3: send_text("+12");
                        4: send_text("12 ");
                        5: send_text("4294967296");
                        6: send_text("99999999999");
                        7: send_text("4294967295x");
                        default: send_text("-5");
                    endcase
                end
            endcase
            send_line_end();
        end
    endtask

    task automatic test_repeated_length_lines();
        if (length_case != LEN_ABSENT) begin
            send_length_key();
            send_text(" 7");
            send_line_end();
            send_length_key();
            send_text(" 4294967296");
            send_line_end();
        end
    endtask

    task automatic test_header_end();
        send_line_end();
    endtask

    task automatic test_body_bytes();
        int n;
        n = (length_case == LEN_VALID) ? body_len + $urandom_range(60, 120) : 300;
        for (int k = 0; k < n; k++) begin
            // long receiver hold-off fills the block, later let it drain fully
            if (k == 40) stall_request = 1'b1;
            if (k == 90) wait_drained();
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop = 1'b0;
        end else begin
            if (stall_request) begin
                holdoff_left  = HOLD_OFF_CYCLES;
                stall_request = 1'b0;
            end
            if (mode_left == 0) begin
                pop_mode  = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            if (holdoff_left > 0) begin
                holdoff_left--;
                pop = 1'b0;
            end else if (draining) begin
                pop = 1'b1;
            end else begin
                case (pop_mode)
                    0: pop = 1'b1;
                    1: pop = ($urandom_range(0, 3) != 0);
                    2: pop = ($urandom_range(0, 3) == 0);
                    default: pop = (mode_left % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (framed_q.size() == 0) begin
                if (fault_count < REPORT_LIMIT)
                    $display("unexpected item: byte=%h kind=%0d", o_out_byte, o_byte_kind);
                fault_count++;
            end else begin
                want = framed_q.pop_front();
                if (o_out_byte !== want.out_byte || o_byte_kind !== want.byte_kind ||
                    o_header_done !== want.header_done ||
                    o_message_done !== want.message_done ||
                    o_error_code !== want.error_code ||
                    o_length_present !== want.length_present ||
                    o_content_length !== want.content_length) begin
                    if (fault_count < REPORT_LIMIT)
                        $display(
                            "mismatch: exp byte=%h kind=%0d hd=%b md=%b err=%b lp=%b len=%0d",
                            want.out_byte, want.byte_kind, want.header_done,
                            want.message_done, want.error_code, want.length_present,
                            want.content_length,
                            " / got byte=%h kind=%0d hd=%b md=%b err=%b lp=%b len=%0d",
                            o_out_byte, o_byte_kind, o_header_done, o_message_done,
                            o_error_code, o_length_present, o_content_length);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        case ($urandom_range(0, 9))
            0:       length_case = LEN_ZERO;
            1, 2:    length_case = LEN_INVALID;
            3:       length_case = LEN_ABSENT;
            4:       length_case = LEN_EMPTY_START;
            default: length_case = LEN_VALID;
        endcase
        test_start_line();
        test_other_header_lines();
        test_length_line();
        test_repeated_length_lines();
        test_other_header_lines();
        test_header_end();
        test_body_bytes();
        wait_drained();
        draining = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
